// ----- src/ffsa_pkg.sv -----
// Shared types and constants of the first-fit segment allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffsa_pkg;

	// Field widths of the stream and configuration ports.
	localparam int CFG_W      = 21;
	localparam int REQ_SIZE_W = 21;
	localparam int REQ_ADDR_W = 20;
	localparam int RES_ADDR_W = 20;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 24;

	// Defaults for the top-level parameters and the region size after reset.
	localparam int DEF_MAX_SEGMENTS = 16;
	localparam int DEF_REGION_BITS  = 20;
	localparam longint unsigned REGION_RESET = 64'd1048576;

	// Request kinds carried in tuser.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NOFIT    = 2'd1,
		STATUS_NOTALLOC = 2'd2,
		STATUS_FULL     = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// Command broadcast from the controller to every cell.
	typedef struct packed {
		logic init;
		logic commit;
		logic op_free;
	} cell_ctrl_t;

	// Search wave flags handed from one cell to the next.
	typedef struct packed {
		logic hit;
		logic rm;
	} chain_t;

	// Flags a cell hands to the cell after it.
	typedef struct packed {
		logic head;
		logic fvalid;
		logic uvalid;
		logic gt;
	} fwd_flags_t;

	// Flags a cell hands to the cell before it.
	typedef struct packed {
		logic fvalid;
		logic uvalid;
	} bwd_flags_t;

endpackage
`default_nettype wire

// ----- src/ffsa_cell.sv -----
// One cell of the allocator row: a free table entry, a used table entry and a stage of the search wave.
`timescale 1ns / 1ps
`default_nettype none
module ffsa_cell #(
	parameter int ADDR_W = 20,
	parameter int LEN_W  = 21
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffsa_pkg::cell_ctrl_t ctrl,
	input  logic [LEN_W-1:0]     req_size,
	input  logic [ADDR_W-1:0]    req_addr,
	input  logic [LEN_W-1:0]     bcast,
	input  logic [LEN_W-1:0]     region,
	input  ffsa_pkg::chain_t     chain_in,
	input  logic [LEN_W-1:0]     chain_data_in,
	output ffsa_pkg::chain_t     chain_out,
	output logic [LEN_W-1:0]     chain_data_out,
	input  ffsa_pkg::fwd_flags_t prev_flags,
	input  logic [ADDR_W-1:0]    prev_fstart,
	input  logic [LEN_W-1:0]     prev_flen,
	output ffsa_pkg::fwd_flags_t flags,
	output logic [ADDR_W-1:0]    fstart,
	output logic [LEN_W-1:0]     flen,
	input  ffsa_pkg::bwd_flags_t next_flags,
	input  logic [ADDR_W-1:0]    next_fstart,
	input  logic [LEN_W-1:0]     next_flen,
	input  logic [ADDR_W-1:0]    next_ustart,
	input  logic [LEN_W-1:0]     next_ulen,
	output ffsa_pkg::bwd_flags_t back_flags,
	output logic [ADDR_W-1:0]    ustart,
	output logic [LEN_W-1:0]     ulen
);
	import ffsa_pkg::*;

	logic              fvalid_q, uvalid_q;
	logic [ADDR_W-1:0] fstart_q, ustart_q;
	logic [LEN_W-1:0]  flen_q, ulen_q;
	chain_t            chain_q;
	logic [LEN_W-1:0]  chain_data_q;

	logic              fvalid_d, uvalid_d;
	logic [ADDR_W-1:0] fstart_d, ustart_d;
	logic [LEN_W-1:0]  flen_d, ulen_d;

	logic             fit, exact, umatch, match, sel, gt, u_first_empty;
	logic [LEN_W-1:0] own_val;

	// Local compares against the held request.
	assign fit    = fvalid_q && (flen_q >= req_size);
	assign exact  = (flen_q == req_size);
	assign umatch = uvalid_q && (ustart_q == req_addr);
	assign match  = ctrl.op_free ? umatch : fit;
	assign own_val = ctrl.op_free ? ulen_q : LEN_W'(fstart_q);
	assign sel    = match && !chain_q.hit;

	// The free table is sorted, so gt forms a step along the row; u_first_empty marks the first empty used entry.
	assign gt            = !fvalid_q || (fstart_q > req_addr);
	assign u_first_empty = !uvalid_q && prev_flags.uvalid;

	// Search wave: the first hit claims the slot and its value travels on.
	assign chain_out.hit  = chain_q.hit || match;
	assign chain_out.rm   = chain_q.rm || (sel && (ctrl.op_free || exact));
	assign chain_data_out = chain_q.hit ? chain_data_q : (match ? own_val : '0);

	// Neighbour views of this cell.
	assign flags      = '{head: 1'b0, fvalid: fvalid_q, uvalid: uvalid_q, gt: gt};
	assign back_flags = '{fvalid: fvalid_q, uvalid: uvalid_q};
	assign fstart     = fstart_q;
	assign flen       = flen_q;
	assign ustart     = ustart_q;
	assign ulen       = ulen_q;

	// Next contents of the entries on initialisation or commit.
	always_comb begin
		fvalid_d = fvalid_q;
		fstart_d = fstart_q;
		flen_d   = flen_q;
		uvalid_d = uvalid_q;
		ustart_d = ustart_q;
		ulen_d   = ulen_q;
		priority if (ctrl.init) begin
			fvalid_d = prev_flags.head;
			fstart_d = '0;
			flen_d   = region;
			uvalid_d = 1'b0;
		end else if (ctrl.commit && !ctrl.op_free) begin
			// Allocate: close the gap of an exact fit or shrink the split segment.
			priority if (chain_out.rm) begin
				fvalid_d = next_flags.fvalid;
				fstart_d = next_fstart;
				flen_d   = next_flen;
			end else if (sel) begin
				fstart_d = ADDR_W'(LEN_W'(fstart_q) + req_size);
				flen_d   = flen_q - req_size;
			end else begin
				// Cells before the claimed slot, and all cells after a split, keep their free entry.
			end
			if (u_first_empty) begin
				uvalid_d = 1'b1;
				ustart_d = bcast[ADDR_W-1:0];
				ulen_d   = req_size;
			end
		end else if (ctrl.commit) begin
			// Free: close the gap in the used table, open one in the free table.
			if (chain_out.rm) begin
				uvalid_d = next_flags.uvalid;
				ustart_d = next_ustart;
				ulen_d   = next_ulen;
			end
			priority if (gt && !prev_flags.gt) begin
				fvalid_d = 1'b1;
				fstart_d = req_addr;
				flen_d   = bcast;
			end else if (prev_flags.gt) begin
				fvalid_d = prev_flags.fvalid;
				fstart_d = prev_fstart;
				flen_d   = prev_flen;
			end else begin
				// Free entries below the insertion point stay in place.
			end
		end else begin
			// Without a commit every entry holds its contents.
		end
	end

	// Control state of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= 1'b0;
			uvalid_q <= 1'b0;
			chain_q  <= '0;
		end else begin
			fvalid_q <= fvalid_d;
			uvalid_q <= uvalid_d;
			chain_q  <= chain_in;
		end
	end

	// Entry payload and wave data.
	always_ff @(posedge clk) begin
		fstart_q     <= fstart_d;
		flen_q       <= flen_d;
		ustart_q     <= ustart_d;
		ulen_q       <= ulen_d;
		chain_data_q <= chain_data_in;
	end

endmodule
`default_nettype wire

// ----- src/first_fit_segment_allocator_top.sv -----
// Top level of the first-fit segment allocator: controller, request and result registers, cell row.
//
// Requests arrive on the s_ channel: tuser selects allocate or free, tdata carries the size and
// the address. Each accepted item gives exactly one result item on the m_ channel with a status
// and the allocated offset. The tables live in a row of MAX_SEGMENTS cells, each holding one
// free entry and one used entry. A search wave runs down the row one cell per clock, and the
// result is registered at its end; the next item is taken only after that result has been
// registered. The insert or removal itself is done by all cells in the final cycle of the
// search by moving entries to a neighbour.
// A result that is not taken is held in the output register; the next item may be accepted
// meanwhile, and its search then waits at its last cycle until the output register is free.
// After reset, and after each write of region_size, the tables are reinitialised while no item
// is accepted; the free table then holds one segment covering the region.
// Region size writes of zero are taken as one byte, and values above 2^REGION_BITS are clamped.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_segment_allocator_top #(
	parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
	parameter int REGION_BITS  = ffsa_pkg::DEF_REGION_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ffsa_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// req_size [20:0], req_addr [40:21], zero padding above
	input  logic [ffsa_pkg::S_TDATA_W-1:0] s_tdata,
	// req_type
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status [1:0], result_addr [21:2], zero padding above
	output logic [ffsa_pkg::M_TDATA_W-1:0] m_tdata
);
	import ffsa_pkg::*;

	localparam int N      = MAX_SEGMENTS;
	localparam int ADDR_W = (REGION_BITS < CFG_W) ? REGION_BITS : CFG_W;
	localparam int LEN_W  = (REGION_BITS < CFG_W) ? REGION_BITS + 1 : CFG_W;
	localparam int CNT_W  = $clog2(N);
	localparam longint unsigned LIMIT      = 64'd1 << REGION_BITS;
	localparam longint unsigned REGION_RST = (REGION_RESET > LIMIT) ? LIMIT : REGION_RESET;

	state_t     state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic       init_q;
	logic [LEN_W-1:0] region_q;
	logic [CFG_W-1:0] cfg_v0;
	logic [LEN_W-1:0] region_d;

	logic              op_q, size_zero_q, size_over_q, addr_over_q;
	logic [LEN_W-1:0]  size_q;
	logic [ADDR_W-1:0] addr_q;
	logic [REQ_SIZE_W-1:0] size_raw;
	logic [REQ_ADDR_W-1:0] addr_raw;
	logic              size_over, addr_over;

	logic              accept, done, scan_last;
	cell_ctrl_t        ctrl;
	status_t           status_d;
	logic [RES_ADDR_W-1:0] res_addr_d;

	logic              m_tvalid_q;
	status_t           status_q;
	logic [RES_ADDR_W-1:0] res_addr_q;

	// Row interconnect; boundary positions sit at both ends.
	chain_t            chain_s    [0:N];
	logic [LEN_W-1:0]  chain_data [0:N];
	fwd_flags_t        fwd        [0:N];
	bwd_flags_t        bwd        [1:N+1];
	logic [ADDR_W-1:0] fstart_w   [0:N+1];
	logic [LEN_W-1:0]  flen_w     [0:N+1];
	logic [ADDR_W-1:0] ustart_w   [1:N+1];
	logic [LEN_W-1:0]  ulen_w     [1:N+1];
	logic [N-1:0]      fvalid_vec, uvalid_vec;

	// Request fields and their range checks against the internal widths.
	assign size_raw = s_tdata[REQ_SIZE_W-1:0];
	assign addr_raw = s_tdata[REQ_SIZE_W +: REQ_ADDR_W];

	generate
		if (REQ_SIZE_W > LEN_W) begin : g_size_cut
			assign size_over = |size_raw[REQ_SIZE_W-1:LEN_W];
		end else begin : g_size_fit
			assign size_over = 1'b0;
		end
		if (REQ_ADDR_W > ADDR_W) begin : g_addr_cut
			assign addr_over = |addr_raw[REQ_ADDR_W-1:ADDR_W];
		end else begin : g_addr_fit
			assign addr_over = 1'b0;
		end
	endgenerate

	// Region size with out-of-range values clamped.
	assign cfg_v0   = (cfg_wdata == '0) ? CFG_W'(1) : cfg_wdata;
	assign region_d = (64'(cfg_v0) > LIMIT) ? LEN_W'(LIMIT) : LEN_W'(cfg_v0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= LEN_W'(REGION_RST);
			init_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				region_q <= region_d;
			end
			init_q <= cfg_we;
		end
	end

	// Next state of the controller.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		s_tready     = (state_q == ST_IDLE) && !init_q && !cfg_we;
		scan_last    = (state_q == ST_SCAN) && (cnt_q == CNT_W'(N - 1));
		done         = scan_last && (!m_tvalid_q || m_tready);
		ctrl.init    = init_q;
		ctrl.commit  = done && (status_d == STATUS_OK);
		ctrl.op_free = op_q;
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
			end else if ((state_q == ST_SCAN) && !scan_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Request held for the length of the search.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= s_tuser;
			size_q      <= LEN_W'(size_raw);
			size_zero_q <= (size_raw == '0);
			size_over_q <= size_over;
			addr_q      <= ADDR_W'(addr_raw);
			addr_over_q <= addr_over;
		end
	end

	// Result decision from the end of the wave and the table fill.
	always_comb begin
		status_d   = STATUS_OK;
		res_addr_d = '0;
		if (op_q == OP_ALLOC) begin
			priority if (size_zero_q || size_over_q || !chain_s[N].hit) begin
				status_d = STATUS_NOFIT;
			end else if (uvalid_vec[N-1]) begin
				status_d = STATUS_FULL;
			end else begin
				res_addr_d = RES_ADDR_W'(chain_data[N][ADDR_W-1:0]);
			end
		end else begin
			priority if (addr_over_q || !chain_s[N].hit) begin
				status_d = STATUS_NOTALLOC;
			end else if (fvalid_vec[N-1]) begin
				status_d = STATUS_FULL;
			end else begin
				status_d = STATUS_OK;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q   <= status_d;
			res_addr_q <= res_addr_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'({res_addr_q, status_q});

	// Row boundaries.
	assign chain_s[0]    = '{hit: 1'b0, rm: 1'b0};
	assign chain_data[0] = '0;
	assign fwd[0]        = '{head: 1'b1, fvalid: 1'b0, uvalid: 1'b1, gt: 1'b0};
	assign fstart_w[0]   = '0;
	assign flen_w[0]     = '0;
	assign bwd[N+1]      = '{fvalid: 1'b0, uvalid: 1'b0};
	assign fstart_w[N+1] = '0;
	assign flen_w[N+1]   = '0;
	assign ustart_w[N+1] = '0;
	assign ulen_w[N+1]   = '0;

	// The cell row.
	generate
		for (genvar j = 0; j < N; j++) begin : g_cell
			ffsa_cell #(
				.ADDR_W(ADDR_W),
				.LEN_W (LEN_W)
			) u_cell (
				.clk           (clk),
				.arst_n        (arst_n),
				.ctrl          (ctrl),
				.req_size      (size_q),
				.req_addr      (addr_q),
				.bcast         (chain_data[N]),
				.region        (region_q),
				.chain_in      (chain_s[j]),
				.chain_data_in (chain_data[j]),
				.chain_out     (chain_s[j+1]),
				.chain_data_out(chain_data[j+1]),
				.prev_flags    (fwd[j]),
				.prev_fstart   (fstart_w[j]),
				.prev_flen     (flen_w[j]),
				.flags         (fwd[j+1]),
				.fstart        (fstart_w[j+1]),
				.flen          (flen_w[j+1]),
				.next_flags    (bwd[j+2]),
				.next_fstart   (fstart_w[j+2]),
				.next_flen     (flen_w[j+2]),
				.next_ustart   (ustart_w[j+2]),
				.next_ulen     (ulen_w[j+2]),
				.back_flags    (bwd[j+1]),
				.ustart        (ustart_w[j+1]),
				.ulen          (ulen_w[j+1])
			);
			assign fvalid_vec[j] = fwd[j+1].fvalid;
			assign uvalid_vec[j] = bwd[j+1].uvalid;
		end
	endgenerate

	// A result appears only at the end of a search.
	a_result_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_SCAN))
		else $error("result raised outside the end of a search");

	// Both tables stay packed towards the head of the row.
	a_free_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((N'(fvalid_vec + 1'b1) & fvalid_vec) == '0))
		else $error("free table has a hole");

	a_used_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((N'(uvalid_vec + 1'b1) & uvalid_vec) == '0))
		else $error("used table has a hole");

	// The tables only change on initialisation or at the last cycle of a search.
	a_tables_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!init_q && !done) |=> ($stable(fvalid_vec) && $stable(uvalid_vec)))
		else $error("table fill changed without a commit");

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the first-fit segment allocator, with its own allocator model.
`timescale 1ns / 1ps
module testbench;
	import ffsa_pkg::*;

	localparam int SEGS = DEF_MAX_SEGMENTS;
	localparam int CLK_HALF = 5;
	// A search wave down the cell row and the return to idle between items.
	localparam int LATENCY = SEGS + 1;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 400000;
	localparam bit [CFG_W-1:0] REGION_LIMIT = CFG_W'(1 << DEF_REGION_BITS);
	localparam int PAD_W = S_TDATA_W - REQ_ADDR_W - REQ_SIZE_W;

	// One result item as the model expects it.
	typedef struct {
		status_t status;
		bit [RES_ADDR_W-1:0] start;
	} alloc_result_t;

	// Tracks the free and allocated tables and the results still owed by the block.
	class allocator_scoreboard;
		bit [CFG_W-1:0] region;
		bit [RES_ADDR_W-1:0] free_base[SEGS];
		bit [CFG_W-1:0] free_len[SEGS];
		int free_cnt;
		bit [RES_ADDR_W-1:0] used_base[SEGS];
		bit [CFG_W-1:0] used_len[SEGS];
		int used_cnt;
		alloc_result_t expected_results[$];
		int mismatches;

		function new();
			mismatches = 0;
			set_region(CFG_W'(REGION_RESET));
		endfunction

		// A region size write clamps the value and starts over with one free segment.
		function void set_region(bit [CFG_W-1:0] value);
			if (value == '0)
				value = CFG_W'(1);
			else if (value > REGION_LIMIT)
				value = REGION_LIMIT;
			region = value;
			free_base[0] = '0;
			free_len[0] = value;
			free_cnt = 1;
			used_cnt = 0;
		endfunction

		function bit [CFG_W-1:0] largest_free();
			bit [CFG_W-1:0] best;
			best = '0;
			for (int k = 0; k < free_cnt; k++)
				if (free_len[k] > best)
					best = free_len[k];
			return best;
		endfunction

		// First fit in address order; an exact fit removes the free entry, otherwise its
		// front is split off.
		function void allocate(bit [REQ_SIZE_W-1:0] size, output status_t status,
				output bit [RES_ADDR_W-1:0] start);
			int idx;
			start = '0;
			status = STATUS_OK;
			if (size == '0) begin
				status = STATUS_NOFIT;
				return;
			end
			idx = 0;
			while (idx < free_cnt && free_len[idx] < size)
				idx++;
			if (idx >= free_cnt) begin
				status = STATUS_NOFIT;
				return;
			end
			if (used_cnt >= SEGS) begin
				status = STATUS_FULL;
				return;
			end
			used_base[used_cnt] = free_base[idx];
			used_len[used_cnt] = size;
			used_cnt++;
			start = free_base[idx];
			if (free_len[idx] == size) begin
				for (int k = idx; k < free_cnt - 1; k++) begin
					free_base[k] = free_base[k + 1];
					free_len[k] = free_len[k + 1];
				end
				free_cnt--;
			end else begin
				free_base[idx] = free_base[idx] + RES_ADDR_W'(size);
				free_len[idx] = free_len[idx] - size;
			end
		endfunction

		// The freed segment goes back into the sorted free table without merging.
		function void release_segment(bit [REQ_ADDR_W-1:0] start, output status_t status);
			int idx;
			int pos;
			bit [CFG_W-1:0] len;
			status = STATUS_OK;
			idx = 0;
			while (idx < used_cnt && used_base[idx] != start)
				idx++;
			if (idx >= used_cnt) begin
				status = STATUS_NOTALLOC;
				return;
			end
			if (free_cnt >= SEGS) begin
				status = STATUS_FULL;
				return;
			end
			len = used_len[idx];
			used_base[idx] = used_base[used_cnt - 1];
			used_len[idx] = used_len[used_cnt - 1];
			used_cnt--;
			pos = 0;
			while (pos < free_cnt && free_base[pos] <= start)
				pos++;
			for (int k = free_cnt; k > pos; k--) begin
				free_base[k] = free_base[k - 1];
				free_len[k] = free_len[k - 1];
			end
			free_base[pos] = start;
			free_len[pos] = len;
			free_cnt++;
		endfunction

		// Called for every accepted request item, in order of acceptance.
		function void note_request(logic op, bit [REQ_SIZE_W-1:0] size,
				bit [REQ_ADDR_W-1:0] start);
			alloc_result_t owed;
			owed.start = '0;
			if (op == OP_ALLOC)
				allocate(size, owed.status, owed.start);
			else
				release_segment(start, owed.status);
			expected_results.push_back(owed);
		endfunction

		function void flag_error(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%t: %s", $realtime, msg);
		endfunction

		// Called for every accepted result item.
		function void check_result(logic [M_TDATA_W-1:0] data);
			alloc_result_t owed;
			status_t got_status;
			bit [RES_ADDR_W-1:0] got_start;
			got_status = status_t'(data[STATUS_W-1:0]);
			got_start = data[STATUS_W +: RES_ADDR_W];
			if (expected_results.size() == 0) begin
				flag_error($sformatf("result item with no request outstanding: status %0d addr %0d",
					data[STATUS_W-1:0], got_start));
				return;
			end
			owed = expected_results.pop_front();
			if (got_status !== owed.status)
				flag_error($sformatf("status mismatch: expected %s, got %0d", owed.status.name(),
					data[STATUS_W-1:0]));
			if (got_start !== owed.start)
				flag_error($sformatf("result_addr mismatch: expected %0d, got %0d", owed.start,
					got_start));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	allocator_scoreboard tracker = new();
	int cycles = 0;
	int stall_left = 0;
	int run_left = 0;
	int ready_pick;
	int burst_left = 0;
	bit hold_off_req = 1'b0;

	first_fit_segment_allocator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// Receiver: runs of ready, short and long stalls, and a long hold-off on request.
	always @(posedge clk) begin
		if (hold_off_req) begin
			hold_off_req = 1'b0;
			stall_left = HOLD_CYCLES;
			run_left = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
			m_tready <= 1'b1;
		end else begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 5) begin
				stall_left = $urandom_range(19, 59);
				m_tready <= 1'b0;
			end else if (ready_pick < 35) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else if (ready_pick < 45) begin
				run_left = $urandom_range(40, 120);
				m_tready <= 1'b1;
			end else begin
				run_left = $urandom_range(0, 6);
				m_tready <= 1'b1;
			end
		end
	end

	// Gap before the next request item: mostly none or short, a few long, with bursts.
	function automatic int pick_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (pick < 55)
			return 0;
		if (pick < 80)
			return $urandom_range(1, 3);
		if (pick < 95)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	function automatic bit [REQ_ADDR_W-1:0] any_addr();
		return REQ_ADDR_W'($urandom_range(0, REGION_LIMIT - 1));
	endfunction

	function automatic bit [REQ_SIZE_W-1:0] any_size();
		return REQ_SIZE_W'($urandom_range(0, REGION_LIMIT));
	endfunction

	// Offers one request item and returns at the edge where it is taken; valid stays high.
	task automatic send_request(input logic op, input bit [REQ_SIZE_W-1:0] size,
			input bit [REQ_ADDR_W-1:0] start);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{PAD_W{1'b0}}, start, size};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(op, size, start);
	endtask

	// Stops offering items until every owed result has come and the block has gone quiet.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (tracker.expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
	endtask

	task automatic write_region(input bit [CFG_W-1:0] value);
		wait_until_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_region(value);
	endtask

	// Random traffic: mostly frees of live segments and fitting allocations, some noise.
	task automatic run_random(input int count);
		int pick;
		int idx;
		logic op;
		bit [REQ_SIZE_W-1:0] size;
		bit [REQ_ADDR_W-1:0] start;
		repeat (count) begin
			size = any_size();
			start = any_addr();
			pick = $urandom_range(0, 99);
			if (pick < 40 && tracker.used_cnt > 0) begin
				op = OP_FREE;
				start = tracker.used_base[$urandom_range(0, tracker.used_cnt - 1)];
			end else if (pick < 47) begin
				op = OP_FREE;
				if ($urandom_range(0, 1))
					start = REQ_ADDR_W'($urandom_range(0, tracker.region - 1));
			end else begin
				op = OP_ALLOC;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					size = '0;
				else if (pick < 12)
					size = any_size();
				else if (pick < 20)
					size = tracker.largest_free();
				else if (pick < 30 && tracker.free_cnt > 0) begin
					idx = $urandom_range(0, tracker.free_cnt - 1);
					size = tracker.free_len[idx];
				end else
					size = REQ_SIZE_W'($urandom_range(1, (tracker.region > 12) ?
						tracker.region / 12 : 1));
			end
			send_request(op, size, start);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= OP_ALLOC;
		s_tdata <= '0;
		m_tready <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Region from reset: zero size, whole-region exact fit, empty free table,
		// unknown addresses, splits and the absence of merging.
		send_request(OP_ALLOC, '0, any_addr());
		send_request(OP_ALLOC, REGION_LIMIT, '1);
		send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_FREE, any_size(), '1);
		send_request(OP_FREE, '1, '0);
		send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_ALLOC, REGION_LIMIT - 1, any_addr());
		send_request(OP_FREE, any_size(), 1);
		send_request(OP_FREE, any_size(), '0);
		send_request(OP_ALLOC, REGION_LIMIT, any_addr());
		send_request(OP_FREE, any_size(), '0);

		// Fill the allocated table, then the free table.
		write_region(SEGS + 1);
		for (int n = 0; n < SEGS; n++)
			send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_ALLOC, 2, any_addr());
		for (int n = 0; n < SEGS; n++)
			send_request(OP_FREE, any_size(), REQ_ADDR_W'(n));
		send_request(OP_FREE, any_size(), 200);

		// A zero write gives a one-byte region.
		write_region('0);
		send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_ALLOC, 1, any_addr());
		send_request(OP_FREE, any_size(), '0);
		run_random(40);

		// Oversized write is clamped; the receiver holds off while requests keep coming.
		write_region('1);
		hold_off_req = 1'b1;
		run_random(130);

		write_region(64);
		run_random(100);

		write_region(CFG_W'($urandom_range(1, REGION_LIMIT)));
		run_random(100);
		wait_until_drained();
		run_random(80);

		write_region(REGION_LIMIT);
		run_random(50);

		wait_until_drained();
		if (tracker.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/ffsa_pkg.sv
src/ffsa_cell.sv
src/first_fit_segment_allocator_top.sv
sim/testbench.sv
